// File: src/qnorm_pkg.sv
package qnorm_pkg;

  localparam int UNIT_FRAC = 14;
  localparam int UNIT_BITS = 16;
  localparam int MAG_BITS  = 16;
  localparam int NUM_COMP  = 4;

  typedef logic [UNIT_BITS-1:0] unit_t;
  typedef logic [MAG_BITS-1:0]  mag_t;

endpackage

// File: src/qnorm_core.sv
module qnorm_core #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [COMPONENT_BITS-1:0]      in_comp [qnorm_pkg::NUM_COMP],
  output logic                           out_valid,
  output qnorm_pkg::unit_t               out_unit [qnorm_pkg::NUM_COMP],
  output qnorm_pkg::mag_t                out_mag,
  output logic                           out_zero
);

  localparam int NC    = qnorm_pkg::NUM_COMP;
  localparam int AW    = COMPONENT_BITS;
  localparam int SW    = 2 * AW + 1;
  localparam int RW    = AW + 1;
  localparam int QW    = qnorm_pkg::UNIT_FRAC + 1;
  localparam int DW    = AW + qnorm_pkg::UNIT_FRAC;
  localparam int ULAT  = (RW + 1) / 2;
  localparam int QLAT  = QW;
  // radicand padded at the top so that the last bit pair is bits 1:0
  localparam int NW    = 4 * ULAT;

  // stage one: magnitudes and signs
  logic              s1_valid;
  logic [AW-1:0]     s1_mag [NC];
  logic [NC-1:0]     s1_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    for (int i = 0; i < NC; i++) begin
      s1_neg[i] <= in_comp[i][AW-1];
      s1_mag[i] <= in_comp[i][AW-1] ? (~in_comp[i] + 1'b1) : in_comp[i];
    end
  end

  // stage two: squares
  logic              s2_valid;
  logic [2*AW-1:0]   s2_sq [NC];
  logic [AW-1:0]     s2_mag [NC];
  logic [NC-1:0]     s2_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    for (int i = 0; i < NC; i++) begin
      s2_sq[i]  <= s1_mag[i] * s1_mag[i];
      s2_mag[i] <= s1_mag[i];
    end
    s2_neg <= s1_neg;
  end

  // root pipeline: sum in first slot, then two root bits per stage
  logic [SW-1:0]   r_rem  [ULAT+1];
  logic [RW-1:0]   r_root [ULAT+1];
  logic [NW-1:0]   r_n    [ULAT+1];
  logic            r_valid[ULAT+1];
  logic [AW-1:0]   r_mag  [ULAT+1][NC];
  logic [NC-1:0]   r_neg  [ULAT+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid[0] <= 1'b0;
    end else begin
      r_valid[0] <= s2_valid;
    end
    r_n[0]    <= NW'(SW'(s2_sq[0]) + SW'(s2_sq[1]) + SW'(s2_sq[2]) + SW'(s2_sq[3]));
    r_rem[0]  <= '0;
    r_root[0] <= '0;
    r_mag[0]  <= s2_mag;
    r_neg[0]  <= s2_neg;
  end

  for (genvar g = 0; g < ULAT; g++) begin : g_root
    logic [SW+1:0] rem_c;
    logic [RW-1:0] root_c;
    logic [SW+1:0] trial;
    logic [NW-1:0] n_c;
    always_comb begin
      rem_c  = (SW+2)'(r_rem[g]);
      root_c = r_root[g];
      n_c    = r_n[g];
      for (int k = 0; k < 2; k++) begin
        rem_c = {rem_c[SW-1:0], n_c[NW-1 -: 2]};
        n_c   = {n_c[NW-3:0], 2'b00};
        trial = (SW+2)'({root_c, 2'b01});
        if (rem_c >= trial) begin
          rem_c  = rem_c - trial;
          root_c = {root_c[RW-2:0], 1'b1};
        end else begin
          root_c = {root_c[RW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        r_valid[g+1] <= 1'b0;
      end else begin
        r_valid[g+1] <= r_valid[g];
      end
      r_rem[g+1]  <= rem_c[SW-1:0];
      r_root[g+1] <= root_c;
      r_n[g+1]    <= n_c;
      r_mag[g+1]  <= r_mag[g];
      r_neg[g+1]  <= r_neg[g];
    end
  end

  // divide pipeline: one quotient bit per stage for all four lanes
  logic [RW-1:0]  d_root [QLAT+1];
  logic [DW:0]    d_rem  [QLAT+1][NC];
  logic [QW-1:0]  d_quo  [QLAT+1][NC];
  logic [DW-1:0]  d_num  [QLAT+1][NC];
  logic           d_valid[QLAT+1];
  logic [NC-1:0]  d_neg  [QLAT+1];

  always_comb begin
    d_root[0]  = r_root[ULAT];
    d_valid[0] = r_valid[ULAT];
    d_neg[0]   = r_neg[ULAT];
    for (int i = 0; i < NC; i++) begin
      d_num[0][i] = {r_mag[ULAT][i], qnorm_pkg::UNIT_FRAC'(0)};
      d_rem[0][i] = '0;
      d_quo[0][i] = '0;
    end
  end

  for (genvar g = 0; g < QLAT; g++) begin : g_div
    logic [DW:0]   rem_c [NC];
    logic [QW-1:0] quo_c [NC];
    logic [DW-1:0] num_c [NC];
    logic [DW:0]   shifted [NC];
    always_comb begin
      for (int i = 0; i < NC; i++) begin
        // the quotient fits QW bits, so the top DW-QW+1 bits seed the remainder
        if (g == 0) begin
          shifted[i] = (DW+1)'(d_num[g][i] >> (QW - 1));
          num_c[i]   = d_num[g][i] << (DW - QW + 1);
        end else begin
          shifted[i] = {d_rem[g][i][DW-1:0], d_num[g][i][DW-1]};
          num_c[i]   = d_num[g][i] << 1;
        end
        if (shifted[i] >= (DW+1)'(d_root[g])) begin
          rem_c[i] = shifted[i] - (DW+1)'(d_root[g]);
          quo_c[i] = {d_quo[g][i][QW-2:0], 1'b1};
        end else begin
          rem_c[i] = shifted[i];
          quo_c[i] = {d_quo[g][i][QW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[g+1] <= 1'b0;
      end else begin
        d_valid[g+1] <= d_valid[g];
      end
      d_root[g+1] <= d_root[g];
      d_neg[g+1]  <= d_neg[g];
      d_rem[g+1]  <= rem_c;
      d_quo[g+1]  <= quo_c;
      d_num[g+1]  <= num_c;
    end
  end

  // output register
  logic zero_c;
  assign zero_c = (d_root[QLAT] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= d_valid[QLAT];
    end
    out_zero <= zero_c;
    out_mag  <= (d_root[QLAT] > RW'(16'hFFFF)) ? 16'hFFFF
                                                : qnorm_pkg::MAG_BITS'(d_root[QLAT]);
    for (int i = 0; i < NC; i++) begin
      if (zero_c) begin
        out_unit[i] <= '0;
      end else if (d_neg[QLAT][i]) begin
        out_unit[i] <= 16'(-(17'(d_quo[QLAT][i])));
      end else begin
        out_unit[i] <= 16'(d_quo[QLAT][i]);
      end
    end
  end

endmodule

// File: src/quaternion_normalize.sv
// Quaternion normaliser, fully pipelined.
//
// Raise start with comp_w..comp_z for one cycle to issue a request; busy is
// always low, so a request may be issued in every cycle.
// Each request yields one result: unit_w..unit_z (Q1.14, truncated toward
// zero), magnitude (floor root, saturated at 65535) and zero_length.
// A result is shown for exactly one cycle with done high; the receiver
// cannot stall it, so results must be taken as they come.
// The pipeline steps are absolute value, square, sum, two root bits per
// stage, one quotient bit per stage for all four lanes, output register.
// Throughput is one request per cycle.
// Synchronous reset drops all requests in flight and clears done.
module quaternion_normalize #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [COMPONENT_BITS-1:0] comp_w,
  input  logic [COMPONENT_BITS-1:0] comp_x,
  input  logic [COMPONENT_BITS-1:0] comp_y,
  input  logic [COMPONENT_BITS-1:0] comp_z,
  output logic                      done,
  output logic [15:0]               unit_w,
  output logic [15:0]               unit_x,
  output logic [15:0]               unit_y,
  output logic [15:0]               unit_z,
  output logic [15:0]               magnitude,
  output logic                      zero_length
);

  logic [COMPONENT_BITS-1:0] comp [qnorm_pkg::NUM_COMP];
  qnorm_pkg::unit_t          unit [qnorm_pkg::NUM_COMP];

  assign busy = 1'b0;
  assign comp[0] = comp_w;
  assign comp[1] = comp_x;
  assign comp[2] = comp_y;
  assign comp[3] = comp_z;

  qnorm_core #(.COMPONENT_BITS(COMPONENT_BITS)) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .in_comp  (comp),
    .out_valid(done),
    .out_unit (unit),
    .out_mag  (magnitude),
    .out_zero (zero_length)
  );

  assign unit_w = unit[0];
  assign unit_x = unit[1];
  assign unit_y = unit[2];
  assign unit_z = unit[3];

endmodule
